@@ rtl/stq_pkg.sv @@
// Shared constants, types and request codes of the sorted timer task queue.
package stq_pkg;

    localparam int NUM_TASKS  = 16;
    localparam int TIME_BITS  = 32;
    localparam int ID_SPACE   = 16;
    localparam int ID_W       = 4;
    localparam int REQ_W      = 3;
    localparam int OUT_TIME_W = 32;
    localparam int CNT_W      = $clog2(NUM_TASKS + 1);
    localparam int IDX_W      = $clog2(NUM_TASKS);
    localparam int CALC_W     = (TIME_BITS > OUT_TIME_W) ? TIME_BITS : OUT_TIME_W;

    localparam logic [REQ_W-1:0] REQ_ADD     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REPLACE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ELAPSE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TAKE    = 3'd4;

    localparam logic [OUT_TIME_W-1:0] EMPTY_EXPIRATION = '1;

    typedef logic [TIME_BITS-1:0] tick_ms_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        tick_ms_t        tm;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [REQ_W-1:0]      req_type;
        logic [ID_W-1:0]       task_id;
        logic [OUT_TIME_W-1:0] expiration_ms;
        logic [OUT_TIME_W-1:0] elapsed_ms;
    } req_t;

    typedef struct packed {
        logic                  taken_valid;
        logic [ID_W-1:0]       taken_task;
        logic                  queue_nonempty;
        logic [OUT_TIME_W-1:0] next_expiration;
        logic                  status;
    } res_t;

endpackage

@@ rtl/sorted_timer_task_queue.sv @@
// Top level of the sorted timer task queue: entry memory, sequencer, result register.
//
// Usage notes
//   Input channel (in_valid/in_ready) carries one request word: add, replace,
//   remove, elapse or take, with task_id, expiration_ms and elapsed_ms.
//   Output channel (out_valid/out_ready) returns exactly one result word per
//   request: taken task, queue state, head's remaining time and status.
//   Entries live in one 16-deep memory, head first, sorted by remaining time.
//   Each request that goes ahead walks the occupied entries through the single
//   read port, one entry per cycle, with the write port trailing by one slot.
//   A replace of a queued task walks the entries twice, first to remove the
//   old entry and then to insert the new one; a rejected request, or a take
//   with no expired head, goes straight to the result without a walk.
//   One request at a time: in_ready is high only while the sequencer is idle,
//   so a new request is accepted only once the last one has finished.
//   A finished word sits in the output register; the next request can be
//   accepted while it waits, and a stalled receiver holds the sequencer only
//   when the following result is ready to be written.
//   Reset empties the queue (count and per-task flags cleared); memory
//   contents are left alone; a stale head read while empty is never used.
module sorted_timer_task_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [stq_pkg::REQ_W-1:0]           req_type,
    input  logic [stq_pkg::ID_W-1:0]            task_id,
    input  logic [stq_pkg::OUT_TIME_W-1:0]      expiration_ms,
    input  logic [stq_pkg::OUT_TIME_W-1:0]      elapsed_ms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                taken_valid,
    output logic [stq_pkg::ID_W-1:0]            taken_task,
    output logic                                queue_nonempty,
    output logic [stq_pkg::OUT_TIME_W-1:0]      next_expiration,
    output logic                                status
);

    stq_pkg::req_t                  req;
    stq_pkg::res_t                  res;
    stq_pkg::res_t                  res_reg;
    logic                           out_valid_reg;
    logic                           start;
    logic                           idle;
    logic                           res_free;
    logic                           res_done;

    // memory port signals
    logic                           ram_we;
    logic [stq_pkg::IDX_W-1:0]      ram_waddr;
    stq_pkg::entry_t                ram_wdata;
    logic                           ram_re;
    logic [stq_pkg::IDX_W-1:0]      ram_raddr;
    stq_pkg::entry_t                ram_rdata;

    assign req.req_type      = req_type;
    assign req.task_id       = task_id;
    assign req.expiration_ms = expiration_ms;
    assign req.elapsed_ms    = elapsed_ms;

    assign in_ready = idle;
    assign start    = in_valid && idle;

    // result register is free when empty or being drained this cycle
    assign res_free = !out_valid_reg || out_ready;

    stq_ram #(
        .WIDTH (stq_pkg::ENTRY_W),
        .DEPTH (stq_pkg::NUM_TASKS)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    stq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .idle      (idle),
        .res_free  (res_free),
        .done      (res_done),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_done)
            begin
                out_valid_reg <= 1'b1;
                res_reg       <= res;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign taken_valid     = res_reg.taken_valid;
    assign taken_task      = res_reg.taken_task;
    assign queue_nonempty  = res_reg.queue_nonempty;
    assign next_expiration = res_reg.next_expiration;
    assign status          = res_reg.status;

    // an accepted request leaves the sequencer busy in the following cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while sequencer still busy");

    // a finished word never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_done |-> (!out_valid_reg || out_ready))
        else $error("result word overwritten");

    // empty queue reports all-ones head time
    a_empty_time: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !queue_nonempty)
            |-> (next_expiration == stq_pkg::EMPTY_EXPIRATION))
        else $error("empty queue with finite head time");

    // no dequeued task without a take, and a rejected add dequeues nothing
    a_taken_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (!taken_valid || status))
            |-> (taken_task == '0 && !(taken_valid && status)))
        else $error("inconsistent taken task fields");

endmodule

@@ rtl/stq_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/stq_ctrl.sv @@
// Sequencer: walks the entry memory to insert, remove, age and dequeue tasks.
module stq_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  stq_pkg::req_t                    req,
    output logic                             idle,
    input  logic                             res_free,
    output logic                             done,
    output stq_pkg::res_t                    res,
    output logic                             ram_we,
    output logic [stq_pkg::IDX_W-1:0]        ram_waddr,
    output stq_pkg::entry_t                  ram_wdata,
    output logic                             ram_re,
    output logic [stq_pkg::IDX_W-1:0]        ram_raddr,
    input  stq_pkg::entry_t                  ram_rdata
);

    localparam int CALC_W = stq_pkg::CALC_W;
    localparam int TIME_BITS = stq_pkg::TIME_BITS;
    localparam int CNT_W = stq_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_TAIL, S_HEAD_RD, S_HEAD_CAP, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PASS_ADD, PASS_REMOVE, PASS_ELAPSE
    } pass_t;

    state_t                               state_reg;
    pass_t                                pass_reg;
    logic                                 chain_add_reg;
    logic [stq_pkg::ID_W-1:0]             id_reg;
    stq_pkg::tick_ms_t                    time_reg;
    logic [stq_pkg::OUT_TIME_W-1:0]       el_reg;
    logic [CNT_W-1:0]                     cnt_reg;
    logic [stq_pkg::ID_SPACE-1:0]         flags_reg;
    logic [CNT_W-1:0]                     iss_reg;
    logic                                 pend_reg;
    logic [stq_pkg::IDX_W-1:0]            pos_reg;
    logic                                 found_reg;
    logic                                 ins_reg;
    stq_pkg::entry_t                      carry_reg;
    stq_pkg::entry_t                      head_reg;
    logic                                 taken_valid_reg;
    logic [stq_pkg::ID_W-1:0]             taken_task_reg;
    logic                                 status_reg;

    logic                                 id_ok;
    logic                                 full;
    logic                                 flag_hit;
    logic [CALC_W-1:0]                    exp_wide;
    stq_pkg::tick_ms_t                    new_time;
    logic                                 issue;
    logic                                 scan_end;
    logic                                 hit;
    logic                                 later;
    logic [CALC_W-1:0]                    age_a;
    logic [CALC_W-1:0]                    age_b;
    logic [CALC_W-1:0]                    age_diff;
    stq_pkg::tick_ms_t                    aged_time;
    logic [CALC_W-1:0]                    head_wide;

    assign id_ok    = (stq_pkg::NUM_TASKS >= stq_pkg::ID_SPACE)
                   || (int'(req.task_id) < stq_pkg::NUM_TASKS);
    assign full     = (cnt_reg == CNT_W'(stq_pkg::NUM_TASKS));
    assign flag_hit = flags_reg[req.task_id];
    assign exp_wide = CALC_W'(req.expiration_ms);
    assign new_time = exp_wide[TIME_BITS-1:0];
    assign issue    = (state_reg == S_SCAN) && (iss_reg < cnt_reg);
    assign scan_end = !pend_reg && (iss_reg >= cnt_reg);
    assign hit      = (ram_rdata.id == id_reg);
    assign later    = (ram_rdata.tm > time_reg);

    // saturating age of the arriving entry
    assign age_a     = CALC_W'(ram_rdata.tm);
    assign age_b     = CALC_W'(el_reg);
    assign age_diff  = (age_a > age_b) ? (age_a - age_b) : '0;
    assign aged_time = age_diff[TIME_BITS-1:0];

    // memory ports: reads lead writes by one slot, so addresses never collide
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = iss_reg[stq_pkg::IDX_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = ram_rdata;
        unique case (state_reg)
            S_SCAN:
            begin
                ram_re = issue;
                if (pend_reg)
                begin
                    unique case (pass_reg)
                        PASS_ELAPSE:
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = '{id: ram_rdata.id, tm: aged_time};
                        end
                        PASS_REMOVE:
                        begin
                            if (found_reg)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = pos_reg - 1'b1;
                            end
                        end
                        PASS_ADD:
                        begin
                            if (ins_reg)
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = carry_reg;
                            end
                            else if (later)
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = '{id: id_reg, tm: time_reg};
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_TAIL:
            begin
                if (pass_reg == PASS_ADD)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg[stq_pkg::IDX_W-1:0];
                    ram_wdata = ins_reg ? carry_reg
                                        : stq_pkg::entry_t'{id: id_reg, tm: time_reg};
                end
            end
            S_HEAD_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass_reg      <= PASS_ADD;
            chain_add_reg <= 1'b0;
            cnt_reg       <= '0;
            flags_reg     <= '0;
            iss_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            ins_reg       <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        id_reg          <= req.task_id;
                        time_reg        <= new_time;
                        el_reg          <= req.elapsed_ms;
                        iss_reg         <= '0;
                        pend_reg        <= 1'b0;
                        found_reg       <= 1'b0;
                        ins_reg         <= 1'b0;
                        chain_add_reg   <= 1'b0;
                        taken_valid_reg <= 1'b0;
                        taken_task_reg  <= '0;
                        status_reg      <= 1'b0;
                        unique case (req.req_type)
                            stq_pkg::REQ_ADD:
                            begin
                                if (id_ok && flag_hit)
                                begin
                                    status_reg <= 1'b1;
                                    state_reg  <= S_DONE;
                                end
                                else if (id_ok && !full)
                                begin
                                    pass_reg  <= PASS_ADD;
                                    state_reg <= S_SCAN;
                                end
                                else
                                begin
                                    state_reg <= S_DONE;
                                end
                            end
                            stq_pkg::REQ_REPLACE:
                            begin
                                if (id_ok && flag_hit)
                                begin
                                    pass_reg      <= PASS_REMOVE;
                                    chain_add_reg <= 1'b1;
                                    state_reg     <= S_SCAN;
                                end
                                else if (id_ok && !full)
                                begin
                                    pass_reg  <= PASS_ADD;
                                    state_reg <= S_SCAN;
                                end
                                else
                                begin
                                    state_reg <= S_DONE;
                                end
                            end
                            stq_pkg::REQ_REMOVE:
                            begin
                                if (id_ok && flag_hit)
                                begin
                                    pass_reg  <= PASS_REMOVE;
                                    state_reg <= S_SCAN;
                                end
                                else
                                begin
                                    state_reg <= S_DONE;
                                end
                            end
                            stq_pkg::REQ_ELAPSE:
                            begin
                                pass_reg  <= PASS_ELAPSE;
                                state_reg <= S_SCAN;
                            end
                            stq_pkg::REQ_TAKE:
                            begin
                                if ((cnt_reg != '0) && (head_reg.tm == '0))
                                begin
                                    taken_valid_reg <= 1'b1;
                                    taken_task_reg  <= head_reg.id;
                                    id_reg          <= head_reg.id;
                                    pass_reg        <= PASS_REMOVE;
                                    state_reg       <= S_SCAN;
                                end
                                else
                                begin
                                    state_reg <= S_DONE;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    pend_reg <= issue;
                    pos_reg  <= iss_reg[stq_pkg::IDX_W-1:0];
                    if (issue)
                    begin
                        iss_reg <= iss_reg + 1'b1;
                    end
                    if (pend_reg)
                    begin
                        if ((pass_reg == PASS_REMOVE) && !found_reg && hit)
                        begin
                            found_reg <= 1'b1;
                        end
                        if (pass_reg == PASS_ADD)
                        begin
                            if (ins_reg)
                            begin
                                carry_reg <= ram_rdata;
                            end
                            else if (later)
                            begin
                                ins_reg   <= 1'b1;
                                carry_reg <= ram_rdata;
                            end
                        end
                    end
                    if (scan_end)
                    begin
                        state_reg <= S_TAIL;
                    end
                end
                S_TAIL:
                begin
                    if (pass_reg == PASS_ADD)
                    begin
                        cnt_reg           <= cnt_reg + 1'b1;
                        flags_reg[id_reg] <= 1'b1;
                    end
                    else if ((pass_reg == PASS_REMOVE) && found_reg)
                    begin
                        cnt_reg           <= cnt_reg - 1'b1;
                        flags_reg[id_reg] <= 1'b0;
                    end
                    // replace: removal done, now insert
                    if (chain_add_reg && (pass_reg == PASS_REMOVE))
                    begin
                        pass_reg      <= PASS_ADD;
                        chain_add_reg <= 1'b0;
                        iss_reg       <= '0;
                        pend_reg      <= 1'b0;
                        ins_reg       <= 1'b0;
                        state_reg     <= S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_HEAD_RD;
                    end
                end
                S_HEAD_RD:
                begin
                    state_reg <= S_HEAD_CAP;
                end
                S_HEAD_CAP:
                begin
                    head_reg  <= ram_rdata;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (res_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign head_wide = CALC_W'(head_reg.tm);

    assign idle = (state_reg == S_IDLE);
    assign done = (state_reg == S_DONE) && res_free;

    assign res.taken_valid     = taken_valid_reg;
    assign res.taken_task      = taken_task_reg;
    assign res.queue_nonempty  = (cnt_reg != '0);
    assign res.next_expiration = (cnt_reg != '0) ? head_wide[stq_pkg::OUT_TIME_W-1:0]
                                                 : stq_pkg::EMPTY_EXPIRATION;
    assign res.status          = status_reg;

endmodule
